>>> hdl/bgts_pkg.sv
package bgts_pkg;

  localparam int AZ_W   = 16;
  localparam int TIME_W = 32;
  localparam int THR_W  = 15;
  localparam int MS_W   = 16;
  localparam int LVL_W  = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BUMP_LIMIT  = 3'd0,
    REG_COOLDOWN_MS = 3'd1,
    REG_LEVEL_STEP  = 3'd2,
    REG_LEVEL_CAP   = 3'd3,
    REG_SEND_GAP_MS = 3'd4
  } reg_idx_t;

  localparam logic [THR_W-1:0] RST_BUMP_LIMIT  = 15'd3840;
  localparam logic [MS_W-1:0]  RST_COOLDOWN_MS = 16'd300;
  localparam logic [LVL_W-1:0] RST_LEVEL_STEP  = 7'd10;
  localparam logic [LVL_W-1:0] RST_LEVEL_CAP   = 7'd100;
  localparam logic [MS_W-1:0]  RST_SEND_GAP_MS = 16'd20;

  typedef struct packed {
    logic [THR_W-1:0] bump_limit;
    logic [MS_W-1:0]  cooldown_ms;
    logic [LVL_W-1:0] level_step;
    logic [LVL_W-1:0] level_cap;
    logic [MS_W-1:0]  send_gap_ms;
  } cfg_t;

  typedef struct packed {
    logic [LVL_W-1:0] throttle_level;
    logic             transmit_now;
    logic             bump_up;
    logic             bump_down;
    logic             calibrated;
  } res_t;

endpackage

>>> hdl/bgts_cfg_regs.sv
module bgts_cfg_regs #(
  parameter int BASELINE_SAMPLES = 50,
  parameter int LIM_W = 22
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [bgts_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bgts_pkg::CFG_DATA_W-1:0]     cfg_data,
  output bgts_pkg::cfg_t                      cfg,
  output logic [LIM_W-1:0]                    lim
);
  import bgts_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bump_limit  <= RST_BUMP_LIMIT;
      cfg.cooldown_ms <= RST_COOLDOWN_MS;
      cfg.level_step  <= RST_LEVEL_STEP;
      cfg.level_cap   <= RST_LEVEL_CAP;
      cfg.send_gap_ms <= RST_SEND_GAP_MS;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BUMP_LIMIT:  cfg.bump_limit  <= cfg_data[THR_W-1:0];
        REG_COOLDOWN_MS: cfg.cooldown_ms <= cfg_data[MS_W-1:0];
        REG_LEVEL_STEP:  cfg.level_step  <= cfg_data[LVL_W-1:0];
        REG_LEVEL_CAP:   cfg.level_cap   <= cfg_data[LVL_W-1:0];
        REG_SEND_GAP_MS: cfg.send_gap_ms <= cfg_data[MS_W-1:0];
        default: ;
      endcase
    end
  end

  // scaled threshold, loaded together with the register
  always_ff @(posedge clk) begin
    if (rst) begin
      lim <= LIM_W'(RST_BUMP_LIMIT) * LIM_W'(BASELINE_SAMPLES);
    end else if (cfg_write && (cfg_index == REG_BUMP_LIMIT)) begin
      lim <= LIM_W'(cfg_data[THR_W-1:0]) * LIM_W'(BASELINE_SAMPLES);
    end
  end

endmodule

>>> hdl/bgts_calc.sv
module bgts_calc #(
  parameter int BASELINE_SAMPLES = 50,
  parameter int CW = 6,
  parameter int PW = 23,
  parameter int LIM_W = 21
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             go,
  input  bgts_pkg::cfg_t                   cfg,
  input  logic [LIM_W-1:0]                 lim,
  input  logic signed [bgts_pkg::AZ_W-1:0] az,
  input  logic signed [PW-1:0]             prod,
  input  logic signed [PW-1:0]             prodm1,
  input  logic [bgts_pkg::TIME_W-1:0]      now,
  output bgts_pkg::res_t                   res
);
  import bgts_pkg::*;

  localparam int SUM_W = PW - 1;
  localparam int DEV_W = PW + 1;
  localparam logic [CW-1:0] NCOUNT = CW'(BASELINE_SAMPLES);

  logic signed [SUM_W-1:0] baseline_sum, baseline_sum_next;
  logic [CW-1:0]           sample_count, sample_count_next;
  logic                    baseline_done, baseline_done_next;
  logic [LVL_W-1:0]        throttle_value, throttle_value_next;
  logic [TIME_W-1:0]       last_bump_time, last_bump_time_next;
  logic [TIME_W-1:0]       last_send_time, last_send_time_next;

  logic signed [PW-1:0]    sel;
  logic signed [DEV_W-1:0] dev, limx;
  logic                    gt, lt, cool_ok, up, down, tx;
  logic [TIME_W-1:0]       since_bump, since_send;
  logic [LVL_W:0]          up_sum;
  logic signed [LVL_W:0]   dn_dif;
  logic [LVL_W-1:0]        up_val, dn_val;

  always_comb begin
    baseline_sum_next  = baseline_sum;
    sample_count_next  = sample_count;
    baseline_done_next = baseline_done;
    if (!baseline_done) begin
      baseline_sum_next  = baseline_sum + SUM_W'(az);
      sample_count_next  = sample_count + CW'(1);
      baseline_done_next = (sample_count_next >= NCOUNT);
    end

    // sample that completes the baseline: N*az - (sum + az) = (N-1)*az - sum
    sel  = baseline_done ? prod : prodm1;
    dev  = DEV_W'(sel) - DEV_W'(baseline_sum);
    limx = $signed({{(DEV_W-LIM_W){1'b0}}, lim});
    gt   = dev > limx;
    lt   = dev < -limx;

    since_bump = now - last_bump_time;
    cool_ok    = since_bump > {{(TIME_W-MS_W){1'b0}}, cfg.cooldown_ms};
    up         = baseline_done_next && cool_ok && gt;
    down       = baseline_done_next && cool_ok && !gt && lt;

    up_sum = {1'b0, throttle_value} + {1'b0, cfg.level_step};
    up_val = (up_sum > {1'b0, cfg.level_cap}) ? cfg.level_cap : up_sum[LVL_W-1:0];
    dn_dif = $signed({1'b0, throttle_value}) - $signed({1'b0, cfg.level_step});
    if (dn_dif[LVL_W]) begin
      dn_val = '0;
    end else if (dn_dif[LVL_W-1:0] > cfg.level_cap) begin
      dn_val = cfg.level_cap;
    end else begin
      dn_val = dn_dif[LVL_W-1:0];
    end

    throttle_value_next = throttle_value;
    last_bump_time_next = last_bump_time;
    if (up) begin
      throttle_value_next = up_val;
      last_bump_time_next = now;
    end else if (down) begin
      throttle_value_next = dn_val;
      last_bump_time_next = now;
    end

    since_send          = now - last_send_time;
    tx                  = since_send >= {{(TIME_W-MS_W){1'b0}}, cfg.send_gap_ms};
    last_send_time_next = tx ? now : last_send_time;

    res.throttle_level = throttle_value_next;
    res.transmit_now   = tx;
    res.bump_up        = up;
    res.bump_down      = down;
    res.calibrated     = baseline_done_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      baseline_sum   <= '0;
      sample_count   <= '0;
      baseline_done  <= 1'b0;
      throttle_value <= '0;
      last_bump_time <= '0;
      last_send_time <= '0;
    end else if (go) begin
      baseline_sum   <= baseline_sum_next;
      sample_count   <= sample_count_next;
      baseline_done  <= baseline_done_next;
      throttle_value <= throttle_value_next;
      last_bump_time <= last_bump_time_next;
      last_send_time <= last_send_time_next;
    end
  end

endmodule

>>> hdl/bump_gesture_throttle_stepper_unit.sv
// Bump gesture throttle stepper.
// Input channel: in_valid/in_stall carry one item (accel_z, time_ms) per
// accepted edge. Output channel: out_valid/out_stall carry one result item
// (throttle_level, transmit_now, bump_up, bump_down, calibrated) per input.
// Configuration: cfg_write/cfg_index/cfg_data write one register per edge;
// write only while no item is in flight.
// Order: an accepted input is held in the input register, then its result
// is taken into the result register and out_valid rises; a held result on
// out_stall keeps the item in the input register. Throughput: one item per
// cycle while out_stall holds no waiting result; the baseline, cooldown,
// throttle and transmit timer state is registered along with the result.
// Reset (rst, synchronous) clears both stages, restores register defaults
// and zeroes baseline, throttle and timestamps.
// While out_stall holds a waiting result, one more item is still taken into
// the input register; after that in_stall rises until the result drains.
module bump_gesture_throttle_stepper_unit #(
  parameter int BASELINE_SAMPLES = 50
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [bgts_pkg::AZ_W-1:0]     accel_z,
  input  logic [bgts_pkg::TIME_W-1:0]          time_ms,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [bgts_pkg::LVL_W-1:0]           throttle_level,
  output logic                                 transmit_now,
  output logic                                 bump_up,
  output logic                                 bump_down,
  output logic                                 calibrated,
  input  logic                                 cfg_write,
  input  logic [bgts_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bgts_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import bgts_pkg::*;

  localparam int NW    = $clog2(BASELINE_SAMPLES + 1);
  localparam int PW    = AZ_W + NW + 1;
  localparam int LIM_W = THR_W + NW;
  localparam logic signed [NW:0] NS  = (NW+1)'(BASELINE_SAMPLES);
  localparam logic signed [NW:0] NS1 = (NW+1)'(BASELINE_SAMPLES - 1);

  cfg_t              cfg;
  logic [LIM_W-1:0]  lim;
  res_t              res, res_q;

  logic                     s1_valid;
  logic signed [AZ_W-1:0]   s1_az;
  logic signed [PW-1:0]     s1_prod, s1_prodm1;
  logic [TIME_W-1:0]        s1_time;
  logic signed [PW-1:0]     prod_in, prodm1_in;
  logic                     in_take, advance;

  assign prod_in   = accel_z * NS;
  assign prodm1_in = accel_z * NS1;

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && out_valid && out_stall;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_az     <= accel_z;
      s1_prod   <= prod_in;
      s1_prodm1 <= prodm1_in;
      s1_time   <= time_ms;
    end
  end

  bgts_cfg_regs #(
    .BASELINE_SAMPLES(BASELINE_SAMPLES),
    .LIM_W(LIM_W)
  ) u_cfg (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .cfg(cfg),
    .lim(lim)
  );

  bgts_calc #(
    .BASELINE_SAMPLES(BASELINE_SAMPLES),
    .CW(NW),
    .PW(PW),
    .LIM_W(LIM_W)
  ) u_calc (
    .clk(clk),
    .rst(rst),
    .go(advance),
    .cfg(cfg),
    .lim(lim),
    .az(s1_az),
    .prod(s1_prod),
    .prodm1(s1_prodm1),
    .now(s1_time),
    .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign throttle_level = res_q.throttle_level;
  assign transmit_now   = res_q.transmit_now;
  assign bump_up        = res_q.bump_up;
  assign bump_down      = res_q.bump_down;
  assign calibrated     = res_q.calibrated;

`ifndef ASSERT_OFF
  a_one_direction: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(bump_up && bump_down))
    else $error("bump up and down on one item");

  a_bump_needs_cal: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (bump_up || bump_down)) |-> calibrated)
    else $error("bump before baseline settled");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid))
    else $error("input stalled with a free stage");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("advanced item did not reach the output");
`endif

endmodule
